// ----- design/htsd_pkg.sv -----
// Shared types and constants for the tree-table stream decoder.
// Used by htsd_ctrl, htsd_datapath and huffman_tree_stream_decoder; no dependencies.
package htsd_pkg;

  // Size of the tree table store and the widths that follow from it.
  localparam int TREE_BYTES = 512;
  localparam int TREE_AW    = $clog2(TREE_BYTES);
  // A child index can reach the node index plus 2 + 2*63 + 1.
  localparam int CHILD_W    = $clog2(TREE_BYTES + 130);
  // The tree length is 2*(b+1) for a header byte b, so at most 512.
  localparam int LEN_W      = 10;

  // Magic bytes of the header.
  localparam logic [7:0] MAGIC_NIBBLE = 8'h24;
  localparam logic [7:0] MAGIC_BYTE   = 8'h28;

  // Fields of a tree node entry: child offset in bits 5..0, leaf flags above.
  localparam int OFFSET_W      = 6;
  localparam int LEAF_ONE_BIT  = 6;
  localparam int LEAF_ZERO_BIT = 7;

  // Error codes reported on the result channel.
  typedef enum logic [1:0] {
    ERR_HEADER = 2'd0,
    ERR_CHILD  = 2'd1,
    ERR_EARLY  = 2'd2
  } err_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      take;      // latch the accepted input request
    logic      byte_op;   // run the parsing step of the latched byte
    logic      rd_entry;  // read the entry of the current node
    logic      rd_sym;    // read the leaf symbol at the child index
    logic      descend;   // move to the inner child and drop one code bit
    logic      leaf;      // consume the symbol and drop one code bit
    logic      fail;      // post an error result and stop decoding the file
    err_kind_t fail_kind;
    logic      clear;     // end of file: return the file state but the tree store to reset
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hdr_fail;    // the latched byte makes the header invalid
    logic word_full;   // the latched byte completes a code word
    logic child_oob;   // the child of this step lies outside the tree
    logic is_leaf;     // the child of this step is a leaf
    logic emit;        // consuming the symbol produces an output byte
    logic leaf_done;   // consuming the symbol finishes the file
    logic bit_last;    // the current code bit is the last of the word
    logic phase_done;  // decoding of this file has ended
    logic last_byte;   // the latched byte closes the file
    logic out_free;    // the output register can take a result this cycle
  } sts_t;

endpackage

// ----- design/htsd_ctrl.sv -----
// Controller state machine of the tree-table stream decoder.
// Depends on htsd_pkg for the command and status structs.
module htsd_ctrl import htsd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    C_IDLE,
    C_BYTE,
    C_ENTRY,
    C_STEP,
    C_LEAF,
    C_FIN
  } ctrl_state_t;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  ctrl_state_t exit_state;

  assign in_ready   = (state_r == C_IDLE);
  // After a byte's work, a closing byte still needs its end-of-file pass.
  assign exit_state = sts.last_byte ? C_FIN : C_IDLE;

  // Next state and commands.
  always_comb begin
    cmd       = '0;
    cmd.fail_kind = ERR_HEADER;
    state_nxt = state_r;
    case (state_r)
      C_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = C_BYTE;
        end
      end
      C_BYTE: begin
        if (sts.hdr_fail) begin
          if (sts.out_free) begin
            cmd.fail      = 1'b1;
            cmd.fail_kind = ERR_HEADER;
            state_nxt     = exit_state;
          end
        end else begin
          cmd.byte_op = 1'b1;
          state_nxt   = sts.word_full ? C_ENTRY : exit_state;
        end
      end
      C_ENTRY: begin
        cmd.rd_entry = 1'b1;
        state_nxt    = C_STEP;
      end
      C_STEP: begin
        if (sts.child_oob) begin
          if (sts.out_free) begin
            cmd.fail      = 1'b1;
            cmd.fail_kind = ERR_CHILD;
            state_nxt     = exit_state;
          end
        end else if (sts.is_leaf) begin
          cmd.rd_sym = 1'b1;
          state_nxt  = C_LEAF;
        end else begin
          cmd.descend = 1'b1;
          state_nxt   = sts.bit_last ? exit_state : C_ENTRY;
        end
      end
      C_LEAF: begin
        if (!sts.emit || sts.out_free) begin
          cmd.leaf = 1'b1;
          if (sts.leaf_done || sts.bit_last) begin
            state_nxt = exit_state;
          end else begin
            state_nxt = C_ENTRY;
          end
        end
      end
      C_FIN: begin
        if (sts.phase_done) begin
          cmd.clear = 1'b1;
          state_nxt = C_IDLE;
        end else if (sts.out_free) begin
          cmd.fail      = 1'b1;
          cmd.fail_kind = ERR_EARLY;
          cmd.clear     = 1'b1;
          state_nxt     = C_IDLE;
        end
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/htsd_datapath.sv -----
// Datapath of the tree-table stream decoder: header parsing, tree store,
// code word register, tree walk and output register. Depends on htsd_pkg.
module htsd_datapath import htsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_is_error,
  output logic [1:0] out_error_kind
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TREE_LEN,
    PH_TREE_LOAD,
    PH_BITS,
    PH_DONE
  } phase_t;

  // File state.
  phase_t             phase_r, phase_nxt;
  logic [2:0]         hc_r, hc_nxt;
  logic               nib_mode_r, nib_mode_nxt;
  logic [31:0]        rem_r, rem_nxt;
  logic [LEN_W-1:0]   tree_len_r, tree_len_nxt;
  logic [LEN_W-1:0]   load_idx_r, load_idx_nxt;
  logic [1:0]         wcnt_r, wcnt_nxt;
  logic [TREE_AW-1:0] node_r, node_nxt;
  logic [3:0]         hi_nib_r, hi_nib_nxt;
  logic               held_r, held_nxt;
  logic [4:0]         bit_idx_r, bit_idx_nxt;
  logic               last_r;
  logic [7:0]         byte_r;
  logic [31:0]        word_r;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_err_r;
  logic [1:0] out_kind_r;

  // Tree store with a registered read port.
  logic [7:0]         tree_mem [TREE_BYTES];
  logic [7:0]         mem_q_r;
  logic [TREE_AW-1:0] rd_addr;
  logic               rd_en;
  logic               wr_en;

  // Combinational helpers.
  logic [1:0]         lane;
  logic [31:0]        rem_or;
  logic [LEN_W-1:0]   len_val;
  logic               len_fail;
  logic               code_bit;
  logic [CHILD_W-1:0] child;
  logic               push_data;
  logic [7:0]         data_val;
  logic [LEN_W-1:0]   load_next;

  // Header size assembly: bytes 1..3 fill lanes 0..2, bytes 4..7 lanes 0..3.
  assign lane     = (hc_r <= 3'd3) ? 2'(hc_r - 3'd1) : hc_r[1:0];
  assign rem_or   = rem_r | (32'(byte_r) << {lane, 3'b000});
  assign len_val  = {1'b0, byte_r, 1'b0} + LEN_W'(2);
  assign len_fail = 32'(len_val) > TREE_BYTES;
  assign load_next = load_idx_r + LEN_W'(1);

  // Tree step on the entry that the last read returned.
  assign code_bit = word_r[bit_idx_r];
  assign child    = CHILD_W'({node_r[TREE_AW-1:1], 1'b0}) + CHILD_W'(2)
                  + CHILD_W'({mem_q_r[OFFSET_W-1:0], 1'b0}) + CHILD_W'(code_bit);

  // Symbol consumption.
  assign push_data = cmd.leaf && sts.emit;
  assign data_val  = nib_mode_r ? {hi_nib_r, mem_q_r[3:0]} : mem_q_r;

  // Status towards the controller.
  always_comb begin
    sts = '0;
    case (phase_r)
      PH_HEADER: begin
        sts.hdr_fail = ((hc_r == 3'd0) && (byte_r != MAGIC_NIBBLE) && (byte_r != MAGIC_BYTE))
                     || ((hc_r == 3'd7) && (rem_or == 32'd0));
      end
      PH_TREE_LEN: begin
        sts.hdr_fail = len_fail;
      end
      default: begin
        sts.hdr_fail = 1'b0;
      end
    endcase
    sts.word_full  = (phase_r == PH_BITS) && (wcnt_r == 2'd3);
    sts.child_oob  = 32'(child) >= 32'(tree_len_r);
    sts.is_leaf    = code_bit ? mem_q_r[LEAF_ONE_BIT] : mem_q_r[LEAF_ZERO_BIT];
    sts.emit       = !nib_mode_r || held_r;
    sts.leaf_done  = sts.emit && (rem_r == 32'd1);
    sts.bit_last   = (bit_idx_r == 5'd0);
    sts.phase_done = (phase_r == PH_DONE);
    sts.last_byte  = last_r;
    sts.out_free   = !out_valid_r || out_ready;
  end

  // Memory port controls.
  assign wr_en   = cmd.byte_op && (phase_r == PH_TREE_LOAD);
  assign rd_en   = cmd.rd_entry || cmd.rd_sym;
  assign rd_addr = cmd.rd_sym ? child[TREE_AW-1:0] : node_r;

  // Next values of the file state.
  always_comb begin
    phase_nxt     = phase_r;
    hc_nxt        = hc_r;
    nib_mode_nxt  = nib_mode_r;
    rem_nxt       = rem_r;
    tree_len_nxt  = tree_len_r;
    load_idx_nxt  = load_idx_r;
    wcnt_nxt      = wcnt_r;
    node_nxt      = node_r;
    hi_nib_nxt    = hi_nib_r;
    held_nxt      = held_r;
    bit_idx_nxt   = bit_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;

    // Parsing step of one byte, also of a byte of a code word.
    if (cmd.byte_op) begin
      case (phase_r)
        PH_HEADER: begin
          if (hc_r == 3'd0) begin
            nib_mode_nxt = (byte_r == MAGIC_NIBBLE);
            hc_nxt       = 3'd1;
          end else if (hc_r <= 3'd3) begin
            rem_nxt = rem_or;
            if ((hc_r == 3'd3) && (rem_or != 32'd0)) begin
              phase_nxt = PH_TREE_LEN;
              hc_nxt    = 3'd0;
            end else begin
              hc_nxt = hc_r + 3'd1;
            end
          end else begin
            rem_nxt = rem_or;
            if (hc_r == 3'd7) begin
              hc_nxt    = 3'd0;
              phase_nxt = PH_TREE_LEN;
            end else begin
              hc_nxt = hc_r + 3'd1;
            end
          end
        end
        PH_TREE_LEN: begin
          tree_len_nxt = len_val;
          load_idx_nxt = '0;
          phase_nxt    = PH_TREE_LOAD;
        end
        PH_TREE_LOAD: begin
          load_idx_nxt = load_next;
          if (load_next >= tree_len_r) begin
            phase_nxt = PH_BITS;
            wcnt_nxt  = 2'd0;
            node_nxt  = '0;
          end
        end
        PH_BITS: begin
          if (wcnt_r == 2'd3) begin
            wcnt_nxt    = 2'd0;
            bit_idx_nxt = 5'd31;
          end else begin
            wcnt_nxt = wcnt_r + 2'd1;
          end
        end
        default: begin
        end
      endcase
    end

    // Inner node: follow the child.
    if (cmd.descend) begin
      node_nxt    = child[TREE_AW-1:0];
      bit_idx_nxt = bit_idx_r - 5'd1;
    end

    // Leaf: back to the root and use the symbol.
    if (cmd.leaf) begin
      node_nxt    = '0;
      bit_idx_nxt = bit_idx_r - 5'd1;
      if (nib_mode_r && !held_r) begin
        hi_nib_nxt = mem_q_r[3:0];
        held_nxt   = 1'b1;
      end else begin
        held_nxt = 1'b0;
        rem_nxt  = rem_r - 32'd1;
        if (rem_r == 32'd1) begin
          phase_nxt = PH_DONE;
        end
      end
    end

    if (cmd.fail) begin
      phase_nxt = PH_DONE;
    end

    if (cmd.fail || push_data) begin
      out_valid_nxt = 1'b1;
    end

    // End of file: all file state but the tree store returns to reset.
    if (cmd.clear) begin
      phase_nxt    = PH_HEADER;
      hc_nxt       = 3'd0;
      nib_mode_nxt = 1'b0;
      rem_nxt      = 32'd0;
      tree_len_nxt = '0;
      load_idx_nxt = '0;
      wcnt_nxt     = 2'd0;
      node_nxt     = '0;
      hi_nib_nxt   = 4'd0;
      held_nxt     = 1'b0;
      bit_idx_nxt  = 5'd0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      hc_r        <= 3'd0;
      nib_mode_r  <= 1'b0;
      rem_r       <= 32'd0;
      tree_len_r  <= '0;
      load_idx_r  <= '0;
      wcnt_r      <= 2'd0;
      node_r      <= '0;
      hi_nib_r    <= 4'd0;
      held_r      <= 1'b0;
      bit_idx_r   <= 5'd0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      hc_r        <= hc_nxt;
      nib_mode_r  <= nib_mode_nxt;
      rem_r       <= rem_nxt;
      tree_len_r  <= tree_len_nxt;
      load_idx_r  <= load_idx_nxt;
      wcnt_r      <= wcnt_nxt;
      node_r      <= node_nxt;
      hi_nib_r    <= hi_nib_nxt;
      held_r      <= held_nxt;
      bit_idx_r   <= bit_idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.take) begin
        last_r <= in_last_byte;
      end
    end
  end

  // Payload registers: latched byte, code word lanes and result fields.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      byte_r <= in_data_byte;
    end
    if (cmd.byte_op && (phase_r == PH_BITS)) begin
      word_r[{wcnt_r, 3'b000} +: 8] <= byte_r;
    end
    if (cmd.fail) begin
      out_byte_r <= 8'd0;
      out_last_r <= 1'b0;
      out_err_r  <= 1'b1;
      out_kind_r <= cmd.fail_kind;
    end else if (push_data) begin
      out_byte_r <= data_val;
      out_last_r <= (rem_r == 32'd1);
      out_err_r  <= 1'b0;
      out_kind_r <= ERR_HEADER;
    end
  end

  // Tree store: one write port for loading, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tree_mem[load_idx_r[TREE_AW-1:0]] <= byte_r;
    end
    if (rd_en) begin
      mem_q_r <= tree_mem[rd_addr];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_last       = out_last_r;
  assign out_is_error   = out_err_r;
  assign out_error_kind = out_kind_r;

endmodule

// ----- design/huffman_tree_stream_decoder.sv -----
// Top level of the tree-table stream decoder: controller plus datapath.
// Depends on htsd_pkg, htsd_ctrl and htsd_datapath.
//
// The block takes a compressed file one byte per request and returns decoded
// bytes, with out_last on the final one and error results (zero byte,
// is_error set, error_kind coded) for a bad header, a child outside the tree
// or a file that ends early. Bytes are handled one at a time. A header, tree
// or partial-word byte is accepted, then parsed. The byte that completes a
// 32-bit code word is accepted and parsed, then walked: a tree entry read and
// a step for every code bit, and a symbol read for every leaf; the walk stops
// early once the file is complete or an error is seen. Every tree step goes
// through the single registered read port of the tree store. The final byte
// of a file is followed by an end-of-file pass. Results sit in an output
// register, and a result waiting there stalls the walk only when the next
// result is due. The tree store holds whatever was loaded for the current
// file; it has no reset and no clearing pass.
module huffman_tree_stream_decoder import htsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_is_error,
  output logic [1:0] out_error_kind
);

  cmd_t cmd;
  sts_t sts;

  // Controller.
  htsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  htsd_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .out_is_error   (out_is_error),
    .out_error_kind (out_error_kind)
  );

  // A result is only loaded when the output register has room for it.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fail || (cmd.leaf && sts.emit)) |-> sts.out_free)
    else $error("result loaded while the output register was still full");

  // The controller issues at most one datapath operation per cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.take, cmd.byte_op, cmd.rd_entry, cmd.rd_sym, cmd.descend, cmd.leaf}))
    else $error("conflicting datapath commands");

  // After the end-of-file pass the block is ready for the next file.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> in_ready)
    else $error("not ready for a new file after the end-of-file pass");

endmodule

// ----- tb/huffman_tree_stream_decoder_test.sv -----
// Self-checking testbench for huffman_tree_stream_decoder: directed and random compressed files.
// A scoreboard class predicts every decoded byte and error result. Depends on htsd_pkg and the RTL.
`timescale 1ns / 100ps

import htsd_pkg::*;

// Parsing position within one compressed file.
typedef enum logic [2:0] {
  ST_HEADER,
  ST_TREE_LEN,
  ST_TREE_LOAD,
  ST_BITS,
  ST_DONE
} file_phase_t;

// One result as it leaves the block.
typedef struct packed {
  logic [7:0] value;
  logic       last;
  logic       err;
  err_kind_t  kind;
} dec_result_t;

// Tracks the decoder state, predicts its results and compares them in order.
class htsd_decode_check;
  dec_result_t due_results[$];
  int unsigned mismatch_count;

  file_phase_t phase;
  int unsigned hdr_count;
  bit          nibble_mode;
  logic [31:0] remaining;
  logic [7:0]  tree_q[TREE_BYTES];
  int unsigned tree_len;
  int unsigned load_idx;
  logic [31:0] word_acc;
  int unsigned word_bytes;
  int unsigned node;
  logic [3:0]  hi_nib;
  bit          hi_held;

  function new();
    restart();
    foreach (tree_q[i]) tree_q[i] = 8'h00;
    mismatch_count = 0;
  endfunction

  // Everything but the tree store goes back to its reset value at the end of a file.
  function void restart();
    phase       = ST_HEADER;
    hdr_count   = 0;
    nibble_mode = 1'b0;
    remaining   = '0;
    tree_len    = 0;
    load_idx    = 0;
    word_acc    = '0;
    word_bytes  = 0;
    node        = 0;
    hi_nib      = '0;
    hi_held     = 1'b0;
  endfunction

  function void post(logic [7:0] value, bit last, bit err, err_kind_t kind);
    dec_result_t r;
    r.value = value;
    r.last  = last;
    r.err   = err;
    r.kind  = kind;
    due_results.push_back(r);
  endfunction

  // An error result stops decoding until the last byte of the file.
  function void abort(err_kind_t kind);
    post(8'h00, 1'b0, 1'b1, kind);
    phase = ST_DONE;
  endfunction

  // Walk the tree over one code word, most significant bit first.
  function void walk_word(logic [31:0] w);
    int          i;
    int unsigned child;
    logic [7:0]  ent;
    logic [7:0]  sym;
    logic        bitv;
    for (i = 31; i >= 0; i--) begin
      bitv  = w[i];
      ent   = tree_q[node];
      child = (node & ~32'd1) + 2 + 2 * int'(ent[OFFSET_W-1:0]) + int'(bitv);
      if (child >= tree_len) begin
        abort(ERR_CHILD);
        return;
      end
      if (ent[bitv ? LEAF_ONE_BIT : LEAF_ZERO_BIT]) begin
        sym  = tree_q[child];
        node = 0;
        // The kind field reads as zero on data results.
        if (!nibble_mode) begin
          remaining--;
          post(sym, remaining == 0, 1'b0, ERR_HEADER);
        end else if (!hi_held) begin
          hi_nib  = sym[3:0];
          hi_held = 1'b1;
        end else begin
          hi_held = 1'b0;
          remaining--;
          post({hi_nib, sym[3:0]}, remaining == 0, 1'b0, ERR_HEADER);
        end
        if (remaining == 0) begin
          phase = ST_DONE;
          return;
        end
      end else begin
        node = child;
      end
    end
  endfunction

  // Note an accepted request and predict the results that it causes.
  function void take_byte(logic [7:0] b, logic last);
    int unsigned len;
    logic [31:0] w;
    case (phase)
      ST_HEADER: begin
        if (hdr_count == 0) begin
          if (b != MAGIC_NIBBLE && b != MAGIC_BYTE) begin
            abort(ERR_HEADER);
          end else begin
            nibble_mode = (b == MAGIC_NIBBLE);
            hdr_count   = 1;
          end
        end else if (hdr_count <= 3) begin
          remaining |= 32'(b) << (8 * (hdr_count - 1));
          if (hdr_count == 3 && remaining != 0) begin
            phase     = ST_TREE_LEN;
            hdr_count = 0;
          end else begin
            hdr_count++;
          end
        end else begin
          remaining |= 32'(b) << (8 * ((hdr_count - 4) & 3));
          if (hdr_count >= 7) begin
            hdr_count = 0;
            if (remaining == 0) abort(ERR_HEADER);
            else phase = ST_TREE_LEN;
          end else begin
            hdr_count++;
          end
        end
      end
      ST_TREE_LEN: begin
        len = 2 * (int'(b) + 1);
        if (len > TREE_BYTES) begin
          abort(ERR_HEADER);
        end else begin
          tree_len = len;
          load_idx = 0;
          phase    = ST_TREE_LOAD;
        end
      end
      ST_TREE_LOAD: begin
        if (load_idx < TREE_BYTES) tree_q[load_idx] = b;
        load_idx++;
        if (load_idx >= tree_len) begin
          phase      = ST_BITS;
          word_acc   = '0;
          word_bytes = 0;
          node       = 0;
        end
      end
      ST_BITS: begin
        word_acc |= 32'(b) << (8 * word_bytes);
        if (word_bytes >= 3) begin
          w          = word_acc;
          word_acc   = '0;
          word_bytes = 0;
          walk_word(w);
        end else begin
          word_bytes++;
        end
      end
      default: ;
    endcase
    // A file that ends before decoding is complete gets one early-end error.
    if (last) begin
      if (phase != ST_DONE) post(8'h00, 1'b0, 1'b1, ERR_EARLY);
      restart();
    end
  endfunction

  task report(string what);
    $display("check failed at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Compare one accepted result with the oldest prediction, field by field.
  task match_result(dec_result_t got);
    dec_result_t want;
    if (due_results.size() == 0) begin
      report($sformatf("unexpected result byte %02h last %0b error %0b kind %0d",
                       got.value, got.last, got.err, got.kind));
      return;
    end
    want = due_results.pop_front();
    if (got.value !== want.value)
      report($sformatf("out_byte %02h, predicted %02h", got.value, want.value));
    if (got.last !== want.last)
      report($sformatf("out_last %0b, predicted %0b", got.last, want.last));
    if (got.err !== want.err)
      report($sformatf("out_is_error %0b, predicted %0b", got.err, want.err));
    if (got.kind !== want.kind)
      report($sformatf("out_error_kind %0d, predicted %0d", got.kind, want.kind));
  endtask
endclass

module huffman_tree_stream_decoder_test;

  localparam int unsigned RANDOM_ITEMS = 330;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned TAIL_CYCLES  = 200;

  typedef enum logic [1:0] {
    FILE_GOOD,
    FILE_SCRAMBLED,
    FILE_NOISE,
    FILE_BULK
  } file_kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_req_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_is_error;
  logic [1:0] out_error_kind;

  htsd_decode_check board = new();
  in_req_t          file_q[$];
  logic [7:0]       tree_img[TREE_BYTES];
  int unsigned      sent_items = 0;
  int unsigned      cycles = 0;
  int unsigned      send_idle_pct = 8;
  int unsigned      recv_idle_pct = 49;

  huffman_tree_stream_decoder i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .out_is_error   (out_is_error),
    .out_error_kind (out_error_kind)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The run is cut off if it hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // The receiver stalls at random.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Predict on every accepted request, then check every accepted result.
  always @(posedge clk) begin
    dec_result_t got;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        board.take_byte(in_data_byte, in_last_byte);
        sent_items++;
      end
      if (out_valid && out_ready) begin
        got.value = out_byte;
        got.last  = out_last;
        got.err   = out_is_error;
        got.kind  = err_kind_t'(out_error_kind);
        board.match_result(got);
      end
    end
  end

  function automatic void add_byte(logic [7:0] d);
    file_q.push_back({d, 1'b0});
  endfunction

  // Mark the final byte of the file being built.
  function automatic void close_file();
    in_req_t r;
    r = file_q.pop_back();
    r.last = 1'b1;
    file_q.push_back(r);
  endfunction

  // Build a full binary tree in breadth-first order with at most max_pairs node pairs,
  // so that every bit sequence decodes; returns the number of table bytes used.
  // Leaf symbols are the random bytes left in place.
  function automatic int unsigned make_tree(int unsigned max_pairs);
    int unsigned open_q[$];
    int unsigned n;
    int unsigned free_pair;
    int unsigned i;
    int          c;
    logic [7:0]  ent;
    for (i = 0; i < TREE_BYTES; i++) tree_img[i] = 8'($urandom);
    open_q.push_back(0);
    free_pair = 2;
    while (open_q.size() > 0) begin
      n   = open_q.pop_front();
      ent = '0;
      ent[OFFSET_W-1:0] = OFFSET_W'((free_pair - (n & ~32'd1) - 2) / 2);
      for (c = 0; c < 2; c++) begin
        if (free_pair / 2 + open_q.size() + 2 <= max_pairs && $urandom_range(0, 99) < 55)
          open_q.push_back(free_pair + c);
        else
          ent[c ? LEAF_ONE_BIT : LEAF_ZERO_BIT] = 1'b1;
      end
      tree_img[n] = ent;
      free_pair += 2;
    end
    return free_pair;
  endfunction

  // Build one compressed file of the given sort into file_q.
  function automatic void make_file(file_kind_t kind);
    int unsigned used;
    int unsigned total;
    int unsigned keep;
    int unsigned i;
    logic [31:0] size;
    bit          nib;
    file_q.delete();
    if (kind == FILE_NOISE) begin
      add_byte($urandom_range(0, 1) ? MAGIC_BYTE : 8'($urandom));
      repeat ($urandom_range(0, 9)) add_byte(8'($urandom));
      close_file();
      return;
    end
    nib  = 1'($urandom_range(0, 1));
    size = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(1, 10));
    add_byte(nib ? MAGIC_NIBBLE : MAGIC_BYTE);
    // Mostly the short size form, sometimes the long one behind a zero short field.
    if ($urandom_range(0, 3) == 0) begin
      repeat (3) add_byte(8'h00);
      for (i = 0; i < 4; i++) add_byte(size[8*i +: 8]);
    end else begin
      for (i = 0; i < 3; i++) add_byte(size[8*i +: 8]);
    end
    used  = make_tree((kind == FILE_BULK) ? 64 : $urandom_range(1, 8));
    total = used + 2 * $urandom_range(0, 2);
    if (kind == FILE_SCRAMBLED) begin
      for (i = 0; i < total; i++) tree_img[i] = 8'($urandom);
    end
    add_byte(8'(total / 2 - 1));
    for (i = 0; i < total; i++) add_byte(tree_img[i]);
    repeat (4 * $urandom_range(1, 5) + $urandom_range(0, 3)) add_byte(8'($urandom));
    // Now and then the file is cut short anywhere.
    if (kind != FILE_BULK && $urandom_range(0, 7) == 0) begin
      keep = $urandom_range(1, file_q.size());
      while (file_q.size() > keep) void'(file_q.pop_back());
    end
    close_file();
  endfunction

  // Offer one request, with a random gap first, and wait until it is taken.
  task automatic send_byte(in_req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= r.data;
    in_last_byte <= r.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_byte(file_q[i]);
    file_q.delete();
  endtask

  // Hold the sender off until every predicted result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.due_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned base;
    int unsigned stage;
    int unsigned cur_stage;
    int unsigned pick;
    bit          bulk_sent;
    int          i;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Bad magic in a one-byte file.
    add_byte(8'h3F);
    close_file();
    send_file();
    // A file that ends right after its magic.
    add_byte(MAGIC_NIBBLE);
    close_file();
    send_file();
    // Long size form that is zero as well.
    add_byte(MAGIC_BYTE);
    for (i = 0; i < 7; i++) add_byte(8'h00);
    close_file();
    send_file();
    // A one-pair tree: every child of the root lies outside it.
    add_byte(MAGIC_BYTE);
    add_byte(8'h01);
    add_byte(8'h00);
    add_byte(8'h00);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'h00);
    close_file();
    send_file();
    drain_results();

    // Random files in three idling stages; a large tree goes in once.
    base      = sent_items;
    cur_stage = 0;
    bulk_sent = 1'b0;
    while (sent_items - base < RANDOM_ITEMS) begin
      stage = (sent_items - base) * 3 / RANDOM_ITEMS;
      if (stage != cur_stage) begin
        cur_stage     = stage;
        send_idle_pct = (stage == 1) ? 49 : 0;
        recv_idle_pct = (stage == 1) ? 8 : 0;
        drain_results();
      end
      if (stage == 1 && !bulk_sent) begin
        make_file(FILE_BULK);
        send_file();
        drain_results();
        bulk_sent = 1'b1;
      end
      pick = $urandom_range(0, 99);
      make_file(pick < 65 ? FILE_GOOD : (pick < 85 ? FILE_SCRAMBLED : FILE_NOISE));
      send_file();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- huffman_tree_stream_decoder.f -----
design/htsd_pkg.sv
design/htsd_ctrl.sv
design/htsd_datapath.sv
design/huffman_tree_stream_decoder.sv
tb/huffman_tree_stream_decoder_test.sv
